// ===== sv/hds_pkg.sv =====
package hds_pkg;

   localparam int TEMP_W     = 38;
   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 128;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COLS_CFG_W = 7;
   localparam int ROWS_CFG_W = 8;
   localparam int FACTOR_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MIN_DIM    = 3;

   localparam int DIFF_W = TEMP_W + 2;
   localparam int PROD_W = DIFF_W + FACTOR_W + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int FRAC_W = 16;
   localparam int QUOT_W = SUM_W - FRAC_W;
   localparam int RES_W  = QUOT_W + 1;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_FACTOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COL_FACTOR = 2'd3;

   localparam logic [COLS_CFG_W-1:0] GRID_COLS_RST = 7'd64;
   localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RST = 8'd80;
   localparam logic [FACTOR_W-1:0]   FACTOR_RST    = 16'd6554;

   localparam logic [TEMP_W-1:0] TEMP_MAX = {TEMP_W{1'b1}};

   typedef struct packed {
      logic r1_vld;
      logic r1_interior;
      logic r2_vld;
      logic r2_done;
   } item_ctl_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic              fell;
      logic              done;
   } rsp_entry_type;

endpackage

// ===== sv/hds_if.sv =====
interface hds_req_if import hds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] cell_temp;

   modport source (output valid, output cell_temp, input ready);
   modport sink (input valid, input cell_temp, output ready);
endinterface

interface hds_rsp_if import hds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] next_temp;
   logic              cell_fell;
   logic              any_fell;
   logic              pass_done;

   modport source (output valid, output next_temp, output cell_fell, output any_fell,
                   output pass_done, input ready);
   modport sink (input valid, input next_temp, input cell_fell, input any_fell,
                 input pass_done, output ready);
endinterface

// ===== sv/hds_line_buf.sv =====
module hds_line_buf import hds_pkg::*; (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   output logic [TEMP_W-1:0] rd_top,
   output logic [TEMP_W-1:0] rd_mid,
   input  logic              wr_en,
   input  logic [COL_W-1:0]  wr_addr,
   input  logic [TEMP_W-1:0] wr_top,
   input  logic [TEMP_W-1:0] wr_mid
);

   logic [TEMP_W-1:0] row_two_above_mem [MAX_COLS];
   logic [TEMP_W-1:0] row_above_mem [MAX_COLS];
   logic [TEMP_W-1:0] rd_top_ff;
   logic [TEMP_W-1:0] rd_mid_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_top_ff <= row_two_above_mem[rd_addr];
         rd_mid_ff <= row_above_mem[rd_addr];
      end
      if (wr_en) begin
         row_two_above_mem[wr_addr] <= wr_top;
         row_above_mem[wr_addr]     <= wr_mid;
      end
   end

   assign rd_top = rd_top_ff;
   assign rd_mid = rd_mid_ff;

endmodule

// ===== sv/hds_stencil.sv =====
module hds_stencil import hds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [FACTOR_W-1:0] row_factor,
   input  logic [FACTOR_W-1:0] col_factor,
   input  logic                s1_vld,
   input  item_ctl_type        s1_ctl,
   input  logic [TEMP_W-1:0]   s1_temp,
   input  logic [TEMP_W-1:0]   s1_top,
   input  logic [TEMP_W-1:0]   s1_mid,
   output logic                push_a_vld,
   output rsp_entry_type       push_a,
   output logic                push_b_vld,
   output rsp_entry_type       push_b
);

   // window: north, centre, south of previous column, centre two columns back
   logic [TEMP_W-1:0] win_n_ff, win_c_ff, win_s_ff, win_w_ff;

   logic                     s2_vld_ff, s3_vld_ff, s4_vld_ff;
   item_ctl_type             s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic signed [DIFF_W-1:0] s2_dr_ff, s2_dc_ff;
   logic [TEMP_W-1:0]        s2_centre_ff, s3_centre_ff, s4_centre_ff;
   logic [TEMP_W-1:0]        s2_mid_ff, s3_mid_ff, s4_mid_ff;
   logic signed [PROD_W-1:0] s3_prow_ff, s3_pcol_ff;
   logic signed [QUOT_W-1:0] s4_quot_ff;

   logic signed [DIFF_W-1:0] dr_in, dc_in;
   logic signed [PROD_W-1:0] prow_in, pcol_in;
   logic signed [SUM_W-1:0]  sum;
   logic signed [RES_W-1:0]  res;
   logic [TEMP_W-1:0]        new_temp;
   logic                     fell;

   assign dr_in = signed'({2'b00, win_n_ff} + {2'b00, win_s_ff} - {1'b0, win_c_ff, 1'b0});
   assign dc_in = signed'({2'b00, win_w_ff} + {2'b00, s1_mid} - {1'b0, win_c_ff, 1'b0});

   assign prow_in = signed'({1'b0, row_factor}) * s2_dr_ff;
   assign pcol_in = signed'({1'b0, col_factor}) * s2_dc_ff;

   assign sum = SUM_W'(s3_prow_ff) + SUM_W'(s3_pcol_ff)
              + signed'(SUM_W'(1 << (FRAC_W - 1)));

   always_comb begin
      res = signed'({{(RES_W-TEMP_W){1'b0}}, s4_centre_ff}) + RES_W'(s4_quot_ff);
      if (res < 0) begin
         new_temp = '0;
      end else if (res > signed'({{(RES_W-TEMP_W){1'b0}}, TEMP_MAX})) begin
         new_temp = TEMP_MAX;
      end else begin
         new_temp = res[TEMP_W-1:0];
      end
      fell = new_temp < s4_centre_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld) begin
         win_n_ff <= s1_top;
         win_c_ff <= s1_mid;
         win_s_ff <= s1_temp;
         win_w_ff <= win_c_ff;
      end
      s2_ctl_ff    <= s1_ctl;
      s2_dr_ff     <= dr_in;
      s2_dc_ff     <= dc_in;
      s2_centre_ff <= win_c_ff;
      s2_mid_ff    <= s1_mid;

      s3_ctl_ff    <= s2_ctl_ff;
      s3_prow_ff   <= prow_in;
      s3_pcol_ff   <= pcol_in;
      s3_centre_ff <= s2_centre_ff;
      s3_mid_ff    <= s2_mid_ff;

      s4_ctl_ff    <= s3_ctl_ff;
      s4_quot_ff   <= sum[SUM_W-1:FRAC_W];
      s4_centre_ff <= s3_centre_ff;
      s4_mid_ff    <= s3_mid_ff;
   end

   always_comb begin
      push_a_vld  = s4_vld_ff && s4_ctl_ff.r1_vld;
      push_a.temp = s4_ctl_ff.r1_interior ? new_temp : s4_centre_ff;
      push_a.fell = s4_ctl_ff.r1_interior && fell;
      push_a.done = 1'b0;
      push_b_vld  = s4_vld_ff && s4_ctl_ff.r2_vld;
      push_b.temp = s4_mid_ff;
      push_b.fell = 1'b0;
      push_b.done = s4_ctl_ff.r2_done;
   end

endmodule

// ===== sv/hds_rsp_queue.sv =====
module hds_rsp_queue import hds_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_a_vld,
   input  rsp_entry_type   push_a,
   input  logic            push_b_vld,
   input  rsp_entry_type   push_b,
   hds_rsp_if.source       rsp_chan
);

   rsp_entry_type         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   head_ff, head_in;
   logic [QUEUE_AW-1:0]   tail_ff, tail_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  fell_seen_ff, fell_seen_in;
   logic [QUEUE_AW-1:0]   tail_b;
   logic                  pop;
   rsp_entry_type         head_entry;

   assign head_entry = entry_ff[head_ff];
   assign pop        = rsp_chan.valid && rsp_chan.ready;
   assign tail_b     = tail_ff + QUEUE_AW'(push_a_vld);

   assign rsp_chan.valid     = count_ff != '0;
   assign rsp_chan.next_temp = head_entry.temp;
   assign rsp_chan.cell_fell = head_entry.fell;
   assign rsp_chan.any_fell  = fell_seen_ff || head_entry.fell;
   assign rsp_chan.pass_done = head_entry.done;

   always_comb begin
      head_in      = head_ff + QUEUE_AW'(pop);
      tail_in      = tail_b + QUEUE_AW'(push_b_vld);
      count_in     = count_ff + QUEUE_CW'(push_a_vld) + QUEUE_CW'(push_b_vld)
                   - QUEUE_CW'(pop);
      fell_seen_in = fell_seen_ff;
      if (pop) begin
         fell_seen_in = head_entry.done ? 1'b0 : (fell_seen_ff || head_entry.fell);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fell_seen_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fell_seen_ff <= fell_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a_vld) begin
         entry_ff[tail_ff] <= push_a;
      end
      if (push_b_vld) begin
         entry_ff[tail_b] <= push_b;
      end
   end

endmodule

// ===== sv/heat_diffusion_stencil_step.sv =====
// channel    dir  payload                                     transaction
// req_chan   in   cell_temp                                   valid && ready
// rsp_chan   out  next_temp, cell_fell, any_fell, pass_done   valid && ready
// csr_*      in   csr_index, csr_data                         csr_write_en
//
// one cell per cycle while req_chan.ready is high; results pass s1-s4 and the queue
// the line buffer read at acceptance and its write in the next cycle set the pipeline
// req_chan.ready drops only when the 8-entry queue lacks room for the cell's results
// reset is synchronous; line buffers are not cleared and need no sweep
module heat_diffusion_stencil_step import hds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hds_req_if.sink               req_chan,
   hds_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [COLS_CFG_W-1:0] grid_cols_ff;
   logic [ROWS_CFG_W-1:0] grid_rows_ff;
   logic [FACTOR_W-1:0]   row_factor_ff;
   logic [FACTOR_W-1:0]   col_factor_ff;

   logic [COL_W-1:0]      col_count_ff, col_count_in;
   logic [ROW_W-1:0]      row_count_ff, row_count_in;
   logic                  row_valid_ff, row_valid_in;
   logic [QUEUE_CW-1:0]   credit_ff, credit_in;

   logic                  s1_vld_ff;
   item_ctl_type          s1_ctl_ff;
   logic [TEMP_W-1:0]     s1_temp_ff;
   logic [COL_W-1:0]      s1_col_ff;

   logic [COLS_CFG_W-1:0] cols_eff;
   logic [ROWS_CFG_W-1:0] rows_eff;
   logic [COL_W-1:0]      col;
   logic [ROW_W-1:0]      row;
   logic                  last_col;
   item_ctl_type          ctl;
   logic [1:0]            n_rsp;
   logic                  accept;
   logic                  pop;

   logic [TEMP_W-1:0]     lb_top, lb_mid;
   logic                  push_a_vld, push_b_vld;
   rsp_entry_type         push_a, push_b;

   always_comb begin
      if (grid_cols_ff < COLS_CFG_W'(MIN_DIM)) begin
         cols_eff = COLS_CFG_W'(MIN_DIM);
      end else if (grid_cols_ff > COLS_CFG_W'(MAX_COLS)) begin
         cols_eff = COLS_CFG_W'(MAX_COLS);
      end else begin
         cols_eff = grid_cols_ff;
      end
      if (grid_rows_ff < ROWS_CFG_W'(MIN_DIM)) begin
         rows_eff = ROWS_CFG_W'(MIN_DIM);
      end else if (grid_rows_ff > ROWS_CFG_W'(MAX_ROWS)) begin
         rows_eff = ROWS_CFG_W'(MAX_ROWS);
      end else begin
         rows_eff = grid_rows_ff;
      end

      col = (COLS_CFG_W'(col_count_ff) >= cols_eff) ? COL_W'(cols_eff - 1'b1) : col_count_ff;
      row = (ROWS_CFG_W'(row_count_ff) >= rows_eff) ? ROW_W'(rows_eff - 1'b1) : row_count_ff;
      last_col = (COLS_CFG_W'(col) + 1'b1) >= cols_eff;

      ctl.r1_vld      = row_valid_ff && (col != '0);
      ctl.r1_interior = (row >= ROW_W'(2)) && (col >= COL_W'(2));
      ctl.r2_vld      = row_valid_ff && last_col;
      ctl.r2_done     = row == '0;
      n_rsp           = 2'(ctl.r1_vld) + 2'(ctl.r2_vld);
   end

   assign req_chan.ready = (QUEUE_CW'(credit_ff) + QUEUE_CW'(n_rsp))
                           <= QUEUE_CW'(QUEUE_DEPTH);
   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      row_valid_in = row_valid_ff;
      if (accept) begin
         if (last_col) begin
            col_count_in = '0;
            row_valid_in = 1'b1;
            row_count_in = ((ROWS_CFG_W'(row) + 1'b1) >= rows_eff) ? '0 : row + 1'b1;
         end else begin
            col_count_in = col + 1'b1;
            row_count_in = row;
         end
      end
      credit_in = credit_ff + (accept ? QUEUE_CW'(n_rsp) : '0) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff  <= GRID_COLS_RST;
         grid_rows_ff  <= GRID_ROWS_RST;
         row_factor_ff <= FACTOR_RST;
         col_factor_ff <= FACTOR_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_GRID_COLS: begin
               grid_cols_ff <= csr_data[COLS_CFG_W-1:0];
            end
            REG_GRID_ROWS: begin
               grid_rows_ff <= csr_data[ROWS_CFG_W-1:0];
            end
            REG_ROW_FACTOR: begin
               row_factor_ff <= csr_data[FACTOR_W-1:0];
            end
            REG_COL_FACTOR: begin
               col_factor_ff <= csr_data[FACTOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         row_valid_ff <= 1'b0;
         credit_ff    <= '0;
         s1_vld_ff    <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         row_valid_ff <= row_valid_in;
         credit_ff    <= credit_in;
         s1_vld_ff    <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff  <= ctl;
      s1_temp_ff <= req_chan.cell_temp;
      s1_col_ff  <= col;
   end

   hds_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_top  (lb_top),
      .rd_mid  (lb_mid),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_col_ff),
      .wr_top  (lb_mid),
      .wr_mid  (s1_temp_ff)
   );

   hds_stencil u_stencil (
      .clock      (clock),
      .reset      (reset),
      .row_factor (row_factor_ff),
      .col_factor (col_factor_ff),
      .s1_vld     (s1_vld_ff),
      .s1_ctl     (s1_ctl_ff),
      .s1_temp    (s1_temp_ff),
      .s1_top     (lb_top),
      .s1_mid     (lb_mid),
      .push_a_vld (push_a_vld),
      .push_a     (push_a),
      .push_b_vld (push_b_vld),
      .push_b     (push_b)
   );

   hds_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_a_vld (push_a_vld),
      .push_a     (push_a),
      .push_b_vld (push_b_vld),
      .push_b     (push_b),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== tb/heat_diffusion_stencil_step_tb.sv =====
`timescale 1ns / 100ps

module heat_diffusion_stencil_step_tb;
   import hds_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int QUIET_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRINT_LIMIT   = 50;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic              fell;
      logic              any;
      logic              done;
   } cell_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   hds_req_if req_chan ();
   hds_rsp_if rsp_chan ();

   heat_diffusion_stencil_step dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // grid state as the block should hold it
   logic [TEMP_W-1:0] line_above     [MAX_COLS] = '{default: '0};
   logic [TEMP_W-1:0] line_two_above [MAX_COLS] = '{default: '0};
   logic [TEMP_W-1:0] win [6] = '{default: '0};
   int unsigned row_idx = 0;
   int unsigned col_idx = 0;
   bit fell_so_far = 1'b0;
   bit have_row = 1'b0;

   logic [COLS_CFG_W-1:0] set_cols = GRID_COLS_RST;
   logic [ROWS_CFG_W-1:0] set_rows = GRID_ROWS_RST;
   logic [FACTOR_W-1:0]   set_rf   = FACTOR_RST;
   logic [FACTOR_W-1:0]   set_cf   = FACTOR_RST;

   logic [TEMP_W-1:0] cells_to_send [$];
   cell_result_type   temps_due [$];

   bit cell_taken = 1'b0;
   bit rsp_hold = 1'b0;
   bit start_hold = 1'b0;
   int send_idle_pct = 0;
   int take_stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [TEMP_W-1:0] diffuse(input logic [TEMP_W-1:0] up, down, left,
                                                 right, ctr);
      longint ln, ls, lw, le, lc, rf, cf, acc, r;
      longint ceiling;
      ln = up;
      ls = down;
      lw = left;
      le = right;
      lc = ctr;
      rf = set_rf;
      cf = set_cf;
      ceiling = TEMP_MAX;
      acc = rf * (ln + ls - 2 * lc) + cf * (lw + le - 2 * lc) + 32768;
      r = lc + (acc >>> 16);
      if (r < 0) r = 0;
      if (r > ceiling) r = ceiling;
      return r[TEMP_W-1:0];
   endfunction

   function automatic void push_result(input logic [TEMP_W-1:0] val, input bit fell,
                                       input bit done);
      cell_result_type res;
      bit any;
      any = fell_so_far | fell;
      res.temp = val;
      res.fell = fell;
      res.any = any;
      res.done = done;
      temps_due.push_back(res);
      fell_so_far = done ? 1'b0 : any;
   endfunction

   task automatic advance_grid(input logic [TEMP_W-1:0] new_cell);
      int unsigned ncols, nrows, c;
      logic [TEMP_W-1:0] top, mid, ctr, nv;
      bit row_end;
      ncols = (set_cols < MIN_DIM) ? MIN_DIM : ((set_cols > MAX_COLS) ? MAX_COLS : set_cols);
      nrows = (set_rows < MIN_DIM) ? MIN_DIM : ((set_rows > MAX_ROWS) ? MAX_ROWS : set_rows);
      c = (col_idx >= ncols) ? ncols - 1 : col_idx;
      row_end = (c + 1 >= ncols);
      if (row_idx >= nrows) row_idx = nrows - 1;
      top = line_two_above[c];
      mid = line_above[c];
      if (have_row && c >= 1) begin
         ctr = win[1];
         if (row_idx >= 2 && c >= 2) begin
            nv = diffuse(win[0], win[2], win[4], mid, ctr);
            push_result(nv, nv < ctr, 1'b0);
         end else begin
            push_result(ctr, 1'b0, 1'b0);
         end
      end
      if (have_row && row_end) push_result(mid, 1'b0, row_idx == 0);
      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = top;
      win[1] = mid;
      win[2] = new_cell;
      line_two_above[c] = mid;
      line_above[c] = new_cell;
      if (row_end) begin
         col_idx = 0;
         have_row = 1'b1;
         row_idx = (row_idx + 1 >= nrows) ? 0 : row_idx + 1;
      end else begin
         col_idx = c + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [TEMP_W-1:0] got,
                                  input logic [TEMP_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   // cell driver
   always @(negedge clock) begin
      if (!reset && (!req_chan.valid || cell_taken)) begin
         if (cells_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.cell_temp <= cells_to_send.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result sink
   always @(negedge clock) begin
      rsp_chan.ready <= !rsp_hold && ($urandom_range(0, 99) >= take_stall_pct);
   end

   initial begin : long_hold
      wait (start_hold);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin : result_monitor
      cell_result_type want;
      cell_taken = !reset && req_chan.valid && req_chan.ready;
      if (cell_taken) advance_grid(req_chan.cell_temp);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (temps_due.size() == 0) begin
            report_mismatch("result with none due", rsp_chan.next_temp, '0);
         end else begin
            want = temps_due.pop_front();
            if (rsp_chan.next_temp !== want.temp)
               report_mismatch("next_temp", rsp_chan.next_temp, want.temp);
            if (rsp_chan.cell_fell !== want.fell)
               report_mismatch("cell_fell", rsp_chan.cell_fell, want.fell);
            if (rsp_chan.any_fell !== want.any)
               report_mismatch("any_fell", rsp_chan.any_fell, want.any);
            if (rsp_chan.pass_done !== want.done)
               report_mismatch("pass_done", rsp_chan.pass_done, want.done);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         REG_GRID_COLS:  set_cols = val[COLS_CFG_W-1:0];
         REG_GRID_ROWS:  set_rows = val[ROWS_CFG_W-1:0];
         REG_ROW_FACTOR: set_rf = val[FACTOR_W-1:0];
         REG_COL_FACTOR: set_cf = val[FACTOR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // unused upper bits of the size registers get random junk
   task automatic configure(input int unsigned cols, rows, rf, cf);
      write_reg(REG_GRID_COLS, {9'($urandom_range(0, 511)), 7'(cols)});
      write_reg(REG_GRID_ROWS, {8'($urandom_range(0, 255)), 8'(rows)});
      write_reg(REG_ROW_FACTOR, 16'(rf));
      write_reg(REG_COL_FACTOR, 16'(cf));
   endtask

   task automatic drain();
      while (cells_to_send.size() != 0 || req_chan.valid) @(posedge clock);
      while (temps_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int take_pct);
      send_idle_pct = send_pct;
      take_stall_pct = take_pct;
   endtask

   function automatic int unsigned rand_cols();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return $urandom_range(0, 2);
      if (pick == 1) return $urandom_range(64, 127);
      return $urandom_range(3, 10);
   endfunction

   function automatic int unsigned rand_rows();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return $urandom_range(0, 2);
      if (pick == 1) return $urandom_range(128, 255);
      return $urandom_range(3, 8);
   endfunction

   function automatic int unsigned rand_factor();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 0;
      if (pick == 1) return 32768;
      if (pick == 2) return 65535;
      if (pick == 3) return $urandom_range(0, 65535);
      return $urandom_range(0, 32768);
   endfunction

   // mostly a smooth field around a base, with extremes and noise mixed in
   function automatic logic [TEMP_W-1:0] rand_cell(input logic [TEMP_W-1:0] base);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return '0;
      if (pick < 16) return TEMP_MAX;
      if (pick < 36) return TEMP_W'({$urandom_range(0, 63), $urandom});
      return base + TEMP_W'($urandom_range(0, 1 << 20));
   endfunction

   initial begin : stimulus
      int ph, n, i;
      logic [TEMP_W-1:0] base;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.cell_temp = '0;
      rsp_chan.ready = 1'b0;
      set_idling(10, 74);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // widest grid first so both line buffers hold real data everywhere
      configure(64, 3, $urandom_range(0, 32768), $urandom_range(0, 32768));
      base = TEMP_W'({$urandom_range(0, 31), $urandom});
      repeat (3 * MAX_COLS) cells_to_send.push_back(rand_cell(base));
      drain();

      // hot center clamps at zero, then cold center clamps at the top
      configure(3, 3, 32768, 32768);
      for (i = 0; i < 9; i++) cells_to_send.push_back((i == 4) ? TEMP_MAX : '0);
      for (i = 0; i < 9; i++) cells_to_send.push_back((i == 4) ? '0 : TEMP_MAX);
      drain();
      // undersized grid registers, exact half rounds up
      configure(2, 1, 1, 65535);
      for (i = 0; i < 9; i++) cells_to_send.push_back((i == 1) ? TEMP_W'(32768) : '0);
      drain();

      for (ph = 0; ph < 9; ph++) begin
         if (ph < 3) set_idling(10, 74);
         else if (ph < 6) set_idling(74, 10);
         else set_idling(0, 0);
         if (ph == 3) begin
            configure(0, MAX_ROWS, rand_factor(), rand_factor());
            n = 390;
         end else begin
            configure(rand_cols(), rand_rows(), rand_factor(), rand_factor());
            n = $urandom_range(35, 55);
         end
         if (ph == 6) start_hold = 1'b1;
         base = TEMP_W'({$urandom_range(0, 31), $urandom});
         repeat (n) cells_to_send.push_back(rand_cell(base));
         drain();
      end

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
